[src/mfek_pkg.sv]
// ----------------------------------------------------------------------------
// mfek_pkg
// Shared types and constants of the Edmonds-Karp max-flow block.
// ----------------------------------------------------------------------------
package mfek_pkg;

  localparam int VERTEX_COUNT_DEF = 64;
  localparam int VTX_W   = 6;
  localparam int ECAP_W  = 32;
  localparam int CAP_W   = 44;
  localparam int FLOW_W  = 50;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;

  localparam logic [CAP_W-1:0]  CAP_MAX  = {CAP_W{1'b1}};
  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  localparam logic [CIDX_W-1:0] REG_SOURCE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SINK   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_LIMIT  = 2'd2;

  localparam logic FUNC_RUN = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EDGE_RD, ST_EDGE_WR, ST_RUN_CHK, ST_BFS_INIT,
    ST_DEQ_RD, ST_DEQ, ST_NB_RD, ST_NB_CHK, ST_PUSH_PRD, ST_PUSH_FRD,
    ST_PUSH_FWR, ST_PUSH_RWR, ST_AUG, ST_DONE
  } ctl_state_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLEAR, OP_ACCEPT, OP_EDGE_RD, OP_EDGE_WR, OP_RUN_CHK,
    OP_BFS_INIT, OP_DEQ_RD, OP_DEQ, OP_NB_RD, OP_NB_CHK, OP_PUSH_PRD,
    OP_PUSH_FRD, OP_PUSH_FWR, OP_PUSH_RWR, OP_AUG, OP_DONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   in_ready;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic edge_ok;
    logic run_ok;
    logic lim_hit;
    logic q_empty;
    logic nb_hit;
    logic nb_dst;
    logic nx_last;
    logic walk_end;
    logic out_free;
  } status_t;

endpackage

[src/mfek_ram.sv]
// ----------------------------------------------------------------------------
// mfek_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mfek_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/mfek_ctrl.sv]
// ----------------------------------------------------------------------------
// mfek_ctrl
// Sequencer: edge loads, breadth-first searches, path pushes, matrix clear.
// ----------------------------------------------------------------------------
module mfek_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_func_i,
  input  mfek_pkg::status_t sts_i,
  output mfek_pkg::cmd_t    cmd_o
);

  mfek_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfek_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o.op        = mfek_pkg::OP_NOP;
    cmd_o.in_ready  = 1'b0;
    case (state_q)
      mfek_pkg::ST_CLEAR: begin
        cmd_o.op = mfek_pkg::OP_CLEAR;
        if (sts_i.clr_last) state_d = mfek_pkg::ST_IDLE;
      end
      mfek_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = mfek_pkg::OP_ACCEPT;
          state_d  = (in_func_i == mfek_pkg::FUNC_RUN) ? mfek_pkg::ST_RUN_CHK
                                                       : mfek_pkg::ST_EDGE_RD;
        end
      end
      mfek_pkg::ST_EDGE_RD: begin
        cmd_o.op = mfek_pkg::OP_EDGE_RD;
        state_d  = sts_i.edge_ok ? mfek_pkg::ST_EDGE_WR : mfek_pkg::ST_IDLE;
      end
      mfek_pkg::ST_EDGE_WR: begin
        cmd_o.op = mfek_pkg::OP_EDGE_WR;
        state_d  = mfek_pkg::ST_IDLE;
      end
      mfek_pkg::ST_RUN_CHK: begin
        cmd_o.op = mfek_pkg::OP_RUN_CHK;
        if (!sts_i.run_ok || sts_i.lim_hit) state_d = mfek_pkg::ST_DONE;
        else                                 state_d = mfek_pkg::ST_BFS_INIT;
      end
      mfek_pkg::ST_BFS_INIT: begin
        cmd_o.op = mfek_pkg::OP_BFS_INIT;
        state_d  = mfek_pkg::ST_DEQ_RD;
      end
      mfek_pkg::ST_DEQ_RD: begin
        // empty queue: no path left
        if (sts_i.q_empty) begin
          state_d = mfek_pkg::ST_DONE;
        end else begin
          cmd_o.op = mfek_pkg::OP_DEQ_RD;
          state_d  = mfek_pkg::ST_DEQ;
        end
      end
      mfek_pkg::ST_DEQ: begin
        cmd_o.op = mfek_pkg::OP_DEQ;
        state_d  = mfek_pkg::ST_NB_RD;
      end
      mfek_pkg::ST_NB_RD: begin
        cmd_o.op = mfek_pkg::OP_NB_RD;
        state_d  = mfek_pkg::ST_NB_CHK;
      end
      mfek_pkg::ST_NB_CHK: begin
        cmd_o.op = mfek_pkg::OP_NB_CHK;
        if (sts_i.nb_hit && sts_i.nb_dst) state_d = mfek_pkg::ST_PUSH_PRD;
        else if (sts_i.nx_last)            state_d = mfek_pkg::ST_DEQ_RD;
        else                               state_d = mfek_pkg::ST_NB_RD;
      end
      mfek_pkg::ST_PUSH_PRD: begin
        cmd_o.op = mfek_pkg::OP_PUSH_PRD;
        state_d  = sts_i.walk_end ? mfek_pkg::ST_AUG : mfek_pkg::ST_PUSH_FRD;
      end
      mfek_pkg::ST_PUSH_FRD: begin
        cmd_o.op = mfek_pkg::OP_PUSH_FRD;
        state_d  = mfek_pkg::ST_PUSH_FWR;
      end
      mfek_pkg::ST_PUSH_FWR: begin
        cmd_o.op = mfek_pkg::OP_PUSH_FWR;
        state_d  = mfek_pkg::ST_PUSH_RWR;
      end
      mfek_pkg::ST_PUSH_RWR: begin
        cmd_o.op = mfek_pkg::OP_PUSH_RWR;
        state_d  = mfek_pkg::ST_PUSH_PRD;
      end
      mfek_pkg::ST_AUG: begin
        cmd_o.op = mfek_pkg::OP_AUG;
        state_d  = mfek_pkg::ST_RUN_CHK;
      end
      mfek_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = mfek_pkg::OP_DONE;
          state_d  = mfek_pkg::ST_CLEAR;
        end
      end
      default: begin
        state_d = mfek_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

[src/mfek_dp.sv]
// ----------------------------------------------------------------------------
// mfek_dp
// Datapath: residual matrix, predecessor and queue memories, search state.
// ----------------------------------------------------------------------------
module mfek_dp #(
  parameter int VERTEX_COUNT = mfek_pkg::VERTEX_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mfek_pkg::cmd_t                    cmd_i,
  output mfek_pkg::status_t                 sts_o,
  input  logic                              cfg_we_i,
  input  logic [mfek_pkg::CIDX_W-1:0]       cfg_idx_i,
  input  logic [mfek_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic [mfek_pkg::VTX_W-1:0]        in_from_i,
  input  logic [mfek_pkg::VTX_W-1:0]        in_to_i,
  input  logic [mfek_pkg::ECAP_W-1:0]       in_cap_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [mfek_pkg::FLOW_W-1:0]       out_flow_o,
  output logic                              out_status_o
);

  localparam int VW  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int AW  = 2 * VW;
  localparam int QW  = mfek_pkg::CAP_W + VW;
  localparam logic [VW-1:0] NX_LAST = VW'(VERTEX_COUNT - 1);

  // configuration
  logic [mfek_pkg::VTX_W-1:0] src_q, snk_q;
  logic [mfek_pkg::CNT_W-1:0] lim_q;

  // captured edge
  logic [mfek_pkg::VTX_W-1:0]  from_q, to_q;
  logic [mfek_pkg::ECAP_W-1:0] cap_q;

  logic [AW-1:0]                 clr_q;
  logic [mfek_pkg::FLOW_W-1:0]   flow_q;
  logic [mfek_pkg::CNT_W-1:0]    cnt_q;
  logic                          limited_q;
  logic [VERTEX_COUNT-1:0]       visited_q;
  logic [VW:0]                   head_q, tail_q, steps_q;
  logic [VW-1:0]                 cur_q, nx_q, walk_q, prev_q;
  logic [mfek_pkg::CAP_W-1:0]    amt_q, bott_q;
  logic                          out_valid_q;
  logic [mfek_pkg::FLOW_W-1:0]   out_flow_q;
  logic                          out_status_q;

  // memory ports
  logic                       res_we, pred_we, q_we;
  logic [AW-1:0]              res_waddr, res_raddr;
  logic [mfek_pkg::CAP_W-1:0] res_wdata, res_rdata;
  logic [VW-1:0]              pred_rdata, q_waddr;
  logic [QW-1:0]              q_wdata, q_rdata;

  logic [VW-1:0]              src_v, snk_v;
  logic [AW-1:0]              edge_addr;
  logic [mfek_pkg::CAP_W-1:0] add_b, nb_amt, fwd_sub;
  logic [mfek_pkg::CAP_W:0]   add_sum;
  logic [mfek_pkg::FLOW_W:0]  flow_sum;
  logic                       nb_hit, nb_dst, enq_ok;

  assign src_v     = VW'(src_q);
  assign snk_v     = VW'(snk_q);
  assign edge_addr = {VW'(from_q), VW'(to_q)};

  // residual add shared by edge loads and reverse updates, saturating
  assign add_b   = (cmd_i.op == mfek_pkg::OP_EDGE_WR) ? mfek_pkg::CAP_W'(cap_q) : bott_q;
  assign add_sum = {1'b0, res_rdata} + {1'b0, add_b};
  assign fwd_sub = (res_rdata >= bott_q) ? (res_rdata - bott_q) : '0;
  assign nb_amt  = (amt_q < res_rdata) ? amt_q : res_rdata;
  assign nb_hit  = !visited_q[nx_q] && (res_rdata != '0);
  assign nb_dst  = (nx_q == snk_v);
  assign enq_ok  = 32'(tail_q) < 32'(VERTEX_COUNT);
  assign flow_sum = {1'b0, flow_q} + (mfek_pkg::FLOW_W + 1)'(bott_q);

  always_comb begin
    res_we    = 1'b0;
    res_waddr = edge_addr;
    res_wdata = '0;
    res_raddr = edge_addr;
    case (cmd_i.op)
      mfek_pkg::OP_CLEAR: begin
        res_we    = 1'b1;
        res_waddr = clr_q;
      end
      mfek_pkg::OP_EDGE_WR: begin
        res_we    = 1'b1;
        res_wdata = add_sum[mfek_pkg::CAP_W] ? mfek_pkg::CAP_MAX
                                             : add_sum[mfek_pkg::CAP_W-1:0];
      end
      mfek_pkg::OP_NB_RD: begin
        res_raddr = {cur_q, nx_q};
      end
      mfek_pkg::OP_PUSH_FRD: begin
        res_raddr = {pred_rdata, walk_q};
      end
      mfek_pkg::OP_PUSH_FWR: begin
        res_we    = 1'b1;
        res_waddr = {prev_q, walk_q};
        res_wdata = fwd_sub;
        res_raddr = {walk_q, prev_q};
      end
      mfek_pkg::OP_PUSH_RWR: begin
        res_we    = 1'b1;
        res_waddr = {walk_q, prev_q};
        res_wdata = add_sum[mfek_pkg::CAP_W] ? mfek_pkg::CAP_MAX
                                             : add_sum[mfek_pkg::CAP_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign pred_we = (cmd_i.op == mfek_pkg::OP_NB_CHK) && nb_hit;

  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail_q[VW-1:0];
    q_wdata = {nb_amt, nx_q};
    if (cmd_i.op == mfek_pkg::OP_BFS_INIT) begin
      q_we    = 1'b1;
      q_waddr = '0;
      q_wdata = {mfek_pkg::CAP_MAX, src_v};
    end else if (cmd_i.op == mfek_pkg::OP_NB_CHK) begin
      q_we = nb_hit && !nb_dst && enq_ok;
    end
  end

  mfek_ram #(.WIDTH(mfek_pkg::CAP_W), .DEPTH(1 << AW)) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .raddr_i (res_raddr),
    .rdata_o (res_rdata)
  );

  mfek_ram #(.WIDTH(VW), .DEPTH(1 << VW)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (pred_we),
    .waddr_i (nx_q),
    .wdata_i (cur_q),
    .raddr_i (walk_q),
    .rdata_o (pred_rdata)
  );

  mfek_ram #(.WIDTH(QW), .DEPTH(1 << VW)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (head_q[VW-1:0]),
    .rdata_o (q_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q       <= '0;
      snk_q       <= mfek_pkg::VTX_W'(63);
      lim_q       <= '0;
      clr_q       <= '0;
      visited_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mfek_pkg::REG_SOURCE: src_q <= cfg_data_i[mfek_pkg::VTX_W-1:0];
          mfek_pkg::REG_SINK:   snk_q <= cfg_data_i[mfek_pkg::VTX_W-1:0];
          mfek_pkg::REG_LIMIT:  lim_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      case (cmd_i.op)
        mfek_pkg::OP_CLEAR:    clr_q <= clr_q + 1'b1;
        mfek_pkg::OP_BFS_INIT: begin
          visited_q <= {{(VERTEX_COUNT-1){1'b0}}, 1'b1} << src_v;
          head_q    <= '0;
          tail_q    <= (VW + 1)'(1);
        end
        mfek_pkg::OP_DEQ_RD: head_q <= head_q + 1'b1;
        mfek_pkg::OP_NB_CHK: begin
          if (nb_hit) begin
            visited_q[nx_q] <= 1'b1;
            if (!nb_dst && enq_ok) tail_q <= tail_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (cmd_i.op == mfek_pkg::OP_DONE) out_valid_q <= 1'b1;
      else if (out_ready_i)              out_valid_q <= 1'b0;
    end
  end

  // payload and search registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      mfek_pkg::OP_ACCEPT: begin
        from_q    <= in_from_i;
        to_q      <= in_to_i;
        cap_q     <= in_cap_i;
        flow_q    <= '0;
        cnt_q     <= '0;
        limited_q <= 1'b0;
      end
      mfek_pkg::OP_RUN_CHK: limited_q <= sts_o.run_ok && sts_o.lim_hit;
      mfek_pkg::OP_DEQ: begin
        cur_q <= q_rdata[VW-1:0];
        amt_q <= q_rdata[QW-1:VW];
        nx_q  <= '0;
      end
      mfek_pkg::OP_NB_CHK: begin
        nx_q <= nx_q + 1'b1;
        if (nb_hit && nb_dst) begin
          bott_q  <= nb_amt;
          walk_q  <= snk_v;
          steps_q <= '0;
        end
      end
      mfek_pkg::OP_PUSH_FRD: prev_q <= pred_rdata;
      mfek_pkg::OP_PUSH_RWR: begin
        walk_q  <= prev_q;
        steps_q <= steps_q + 1'b1;
      end
      mfek_pkg::OP_AUG: begin
        flow_q <= flow_sum[mfek_pkg::FLOW_W] ? mfek_pkg::FLOW_MAX
                                             : flow_sum[mfek_pkg::FLOW_W-1:0];
        if (cnt_q != mfek_pkg::CNT_MAX) cnt_q <= cnt_q + 1'b1;
      end
      mfek_pkg::OP_DONE: begin
        out_flow_q   <= flow_q;
        out_status_q <= limited_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts_o.clr_last = (clr_q == {AW{1'b1}});
    sts_o.edge_ok  = (32'(from_q) < 32'(VERTEX_COUNT)) && (32'(to_q) < 32'(VERTEX_COUNT));
    sts_o.run_ok   = (32'(src_q) < 32'(VERTEX_COUNT)) && (32'(snk_q) < 32'(VERTEX_COUNT));
    sts_o.lim_hit  = (lim_q != '0) && (cnt_q >= lim_q);
    sts_o.q_empty  = (head_q == tail_q);
    sts_o.nb_hit   = nb_hit;
    sts_o.nb_dst   = nb_dst;
    sts_o.nx_last  = (nx_q == NX_LAST);
    sts_o.walk_end = (walk_q == src_v) || (32'(steps_q) >= 32'(VERTEX_COUNT));
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_flow_o   = out_flow_q;
  assign out_status_o = out_status_q;

endmodule

[src/max_flow_edmonds_karp_top.sv]
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp_top
// Edmonds-Karp max flow over a dense residual matrix held in block RAM.
// ----------------------------------------------------------------------------
// Edge beat: accept, matrix read, matrix write, no result.
// Run beat: accept; each search dequeues vertices and scans their neighbors;
// each augmenting path is pushed hop by hop (predecessor read, forward read,
// forward write, reverse write), then added to the flow; a last check and the
// result finish, plus any wait on a held result. After each run, and after
// reset, a clearing pass zeroes the matrix; no beat is taken meanwhile.
// Reset restores source 0, sink 63, no augmentation limit.
module max_flow_edmonds_karp_top #(
  parameter int VERTEX_COUNT = mfek_pkg::VERTEX_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mfek_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [mfek_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,  // from_vertex, to_vertex, edge_capacity
  input  logic                        s_axis_tuser,  // func
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [55:0]                 m_axis_tdata,  // max_flow
  output logic                        m_axis_tuser   // status
);

  mfek_pkg::cmd_t    cmd;
  mfek_pkg::status_t sts;
  logic [mfek_pkg::FLOW_W-1:0] flow;

  mfek_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mfek_dp #(.VERTEX_COUNT(VERTEX_COUNT)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_from_i    (s_axis_tdata[5:0]),
    .in_to_i      (s_axis_tdata[11:6]),
    .in_cap_i     (s_axis_tdata[43:12]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_flow_o   (flow),
    .out_status_o (m_axis_tuser)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = 56'(flow);

endmodule
